[src/ptsm_pkg.sv]
// shared types and constants of the page table segment mapper
package ptsm_pkg;

  // table pool and table geometry
  localparam int unsigned TABLE_FRAMES      = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned TBL_W             = $clog2(TABLE_FRAMES);
  localparam int unsigned CNT_W             = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned STORE_AW          = $clog2(STORE_DEPTH);

  // address and entry layout
  localparam int unsigned VA_W       = 48;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned LEVELS     = 4;
  localparam int unsigned LVL_W      = $clog2(LEVELS);

  localparam logic [VA_W-1:0]  PAGE_SIZE   = 48'h1000;
  localparam logic [PTE_W-1:0] PTE_PRESENT = 64'h1;
  localparam logic [PTE_W-1:0] PTE_WRITE   = 64'h2;
  localparam logic [PTE_W-1:0] PTE_PU      = 64'h5;

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DATA_FRAME = 2'd0,
    REG_TABLE_BASE = 2'd1,
    REG_USER_BASE  = 2'd2
  } reg_idx_e;

  // command and segment codes
  localparam logic       CMD_NEW_CONTEXT = 1'b0;
  localparam logic       CMD_MAP         = 1'b1;
  localparam logic [1:0] KIND_CODE       = 2'd0;
  localparam logic [1:0] KIND_DATA       = 2'd1;
  localparam logic [1:0] KIND_STACK      = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE         = 2'd0,
    STAT_LEAF_PRESENT = 2'd1,
    STAT_POOL_FAULT   = 2'd2,
    STAT_NO_CONTEXT   = 2'd3
  } status_e;

  typedef struct packed {
    logic            command;
    logic [1:0]      segment_kind;
    logic [VA_W-1:0] segment_start;
    logic [VA_W-1:0] segment_end;
    logic            writable;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] root_frame;
    logic [PTE_W-1:0]   leaf_entry;
  } out_item_t;

endpackage

[src/ptsm_ram.sv]
// generic single write port, single read port ram with registered read
module ptsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/page_table_segment_mapper_core.sv]
// top level of the page table segment mapper: command sequencer and table store
//
// Input items arrive on in_valid_i/in_ready_o with an in_item_t payload; every item
// gives exactly one result item on out_valid_o/out_ready_i. Registers (data frame,
// table frame base, user frame base) sit on the apb port at byte addresses 0, 4, 8.
// Items are processed one at a time; in_ready_o is high only while the sequencer
// is idle. A new-context command sweeps the fresh root table to zero, one entry per
// cycle through the store's single write port, before its result is presented. A map
// command does a store read, then an evaluate and write back, at each level, and
// sweeps every missing table that it creates. Commands that fail at the start (no
// context, pool exhausted on a new context, bad root) go straight to the result.
// The sequencer is idle again when the result is presented. A finished result sits
// in an output register; the sequencer takes the next item while it waits, and a
// further result is held back until that register frees up.
// Reset clears the pool and user counters, the context and the registers. The
// table store has no reset: each table is swept to zero when it is allocated.
module page_table_segment_mapper_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ptsm_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ptsm_pkg::out_item_t              out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptsm_pkg::PADDR_W-1:0]     paddr,
  input  logic [ptsm_pkg::PDATA_W-1:0]     pwdata,
  output logic [ptsm_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam logic [ptsm_pkg::LVL_W-1:0] LEAF_LVL = ptsm_pkg::LVL_W'(ptsm_pkg::LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  function automatic logic [ptsm_pkg::PTE_W-1:0] frame_bits(
    input logic [ptsm_pkg::FRAME_W-1:0] frame
  );
    frame_bits = {{(ptsm_pkg::PTE_W - ptsm_pkg::FRAME_W - ptsm_pkg::PAGE_SHIFT){1'b0}},
                  frame, {ptsm_pkg::PAGE_SHIFT{1'b0}}};
  endfunction

  // configuration registers
  logic [ptsm_pkg::FRAME_W-1:0] data_frame_q;
  logic [ptsm_pkg::FRAME_W-1:0] table_base_q;
  logic [ptsm_pkg::FRAME_W-1:0] user_base_q;

  // sequencer state
  state_e                          state_q;
  logic [ptsm_pkg::CNT_W-1:0]      next_tbl_q;
  logic [ptsm_pkg::FRAME_W-1:0]    next_user_q;
  logic [ptsm_pkg::FRAME_W-1:0]    root_q;
  logic                            ctx_open_q;
  logic [ptsm_pkg::TBL_W-1:0]      tbl_q;
  logic [ptsm_pkg::LVL_W-1:0]      lvl_q;
  logic [ptsm_pkg::IDX_W-1:0]      idx_q [ptsm_pkg::LEVELS];
  logic [ptsm_pkg::IDX_W-1:0]      clr_cnt_q;
  logic                            clr_to_done_q;
  logic                            wr_q;
  logic                            is_data_q;
  ptsm_pkg::status_e               status_q;
  logic [ptsm_pkg::PTE_W-1:0]      leaf_q;
  logic                            out_valid_q;
  ptsm_pkg::out_item_t             out_q;

  // store port
  logic                            ram_we;
  logic [ptsm_pkg::STORE_AW-1:0]   ram_waddr;
  logic [ptsm_pkg::PTE_W-1:0]      ram_wdata;
  logic [ptsm_pkg::STORE_AW-1:0]   ram_raddr;
  logic [ptsm_pkg::PTE_W-1:0]      ram_rdata;

  // walk decisions
  logic [ptsm_pkg::VA_W-1:0]       va_in;
  logic [ptsm_pkg::IDX_W-1:0]      cur_idx;
  logic                            pool_full;
  logic [ptsm_pkg::FRAME_W-1:0]    root_off;
  logic                            root_ok;
  logic                            present;
  logic [ptsm_pkg::FRAME_W-1:0]    child_off;
  logic                            child_ok;
  logic [ptsm_pkg::FRAME_W-1:0]    new_tbl_frame;
  logic [ptsm_pkg::FRAME_W-1:0]    leaf_frame;
  logic [ptsm_pkg::PTE_W-1:0]      wr_mask;
  logic [ptsm_pkg::PTE_W-1:0]      link_new;
  logic [ptsm_pkg::PTE_W-1:0]      leaf_new;
  logic                            upper;

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      ptsm_pkg::REG_DATA_FRAME: prdata = data_frame_q;
      ptsm_pkg::REG_TABLE_BASE: prdata = table_base_q;
      ptsm_pkg::REG_USER_BASE:  prdata = user_base_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_frame_q <= '0;
      table_base_q <= '0;
      user_base_q  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        ptsm_pkg::REG_DATA_FRAME: data_frame_q <= pwdata;
        ptsm_pkg::REG_TABLE_BASE: table_base_q <= pwdata;
        ptsm_pkg::REG_USER_BASE:  user_base_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // walk datapath
  always_comb begin
    // stack maps the page below the segment end, wrapping in 48 bits
    if (in_item_i.segment_kind == ptsm_pkg::KIND_CODE ||
        in_item_i.segment_kind == ptsm_pkg::KIND_DATA) begin
      va_in = in_item_i.segment_start;
    end else begin
      va_in = in_item_i.segment_end - ptsm_pkg::PAGE_SIZE;
    end
  end

  assign cur_idx       = idx_q[lvl_q];
  assign pool_full     = (next_tbl_q == ptsm_pkg::CNT_W'(ptsm_pkg::TABLE_FRAMES));
  assign root_off      = root_q - table_base_q;
  assign root_ok       = (root_off < ptsm_pkg::FRAME_W'(next_tbl_q));
  assign present       = ram_rdata[0];
  assign child_off     = ram_rdata[ptsm_pkg::PAGE_SHIFT +: ptsm_pkg::FRAME_W] - table_base_q;
  assign child_ok      = (child_off < ptsm_pkg::FRAME_W'(next_tbl_q));
  assign new_tbl_frame = table_base_q + ptsm_pkg::FRAME_W'(next_tbl_q);
  assign leaf_frame    = is_data_q ? data_frame_q : (user_base_q + next_user_q);
  assign wr_mask       = wr_q ? ptsm_pkg::PTE_WRITE : '0;
  assign link_new      = ram_rdata | frame_bits(new_tbl_frame) | ptsm_pkg::PTE_PU | wr_mask;
  assign leaf_new      = ram_rdata | frame_bits(leaf_frame) | ptsm_pkg::PTE_PU | wr_mask;
  assign upper         = (lvl_q != LEAF_LVL);

  assign ram_raddr = {tbl_q, cur_idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {tbl_q, cur_idx};
    ram_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {tbl_q, clr_cnt_q};
      end
      S_EVAL: begin
        if (upper) begin
          if (!present) begin
            ram_we    = !pool_full;
            ram_wdata = link_new;
          end else begin
            // existing link only gains the write bit
            ram_we    = child_ok && wr_q;
            ram_wdata = ram_rdata | wr_mask;
          end
        end else begin
          ram_we    = !present;
          ram_wdata = leaf_new;
        end
      end
      default: ;
    endcase
  end

  ptsm_ram #(
    .WIDTH (ptsm_pkg::PTE_W),
    .DEPTH (ptsm_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      next_tbl_q    <= '0;
      next_user_q   <= '0;
      root_q        <= '0;
      ctx_open_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      tbl_q         <= '0;
      lvl_q         <= '0;
      idx_q         <= '{default: '0};
      clr_cnt_q     <= '0;
      clr_to_done_q <= 1'b0;
      wr_q          <= 1'b0;
      is_data_q     <= 1'b0;
      status_q      <= ptsm_pkg::STAT_DONE;
      leaf_q        <= '0;
    end else begin
      // a result leaving while the next one loads is handled in S_DONE
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            wr_q      <= in_item_i.writable;
            is_data_q <= (in_item_i.segment_kind == ptsm_pkg::KIND_DATA);
            for (int k = 0; k < ptsm_pkg::LEVELS; k++) begin
              idx_q[ptsm_pkg::LEVELS-1-k] <=
                va_in[ptsm_pkg::PAGE_SHIFT + ptsm_pkg::IDX_W*k +: ptsm_pkg::IDX_W];
            end
            lvl_q    <= '0;
            leaf_q   <= '0;
            status_q <= ptsm_pkg::STAT_DONE;
            if (in_item_i.command == ptsm_pkg::CMD_NEW_CONTEXT) begin
              if (pool_full) begin
                status_q <= ptsm_pkg::STAT_POOL_FAULT;
                state_q  <= S_DONE;
              end else begin
                tbl_q         <= next_tbl_q[ptsm_pkg::TBL_W-1:0];
                next_tbl_q    <= next_tbl_q + ptsm_pkg::CNT_W'(1);
                root_q        <= new_tbl_frame;
                ctx_open_q    <= 1'b1;
                clr_cnt_q     <= '0;
                clr_to_done_q <= 1'b1;
                state_q       <= S_CLEAR;
              end
            end else if (!ctx_open_q) begin
              status_q <= ptsm_pkg::STAT_NO_CONTEXT;
              state_q  <= S_DONE;
            end else if (!root_ok) begin
              status_q <= ptsm_pkg::STAT_POOL_FAULT;
              state_q  <= S_DONE;
            end else begin
              tbl_q   <= root_off[ptsm_pkg::TBL_W-1:0];
              state_q <= S_READ;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ptsm_pkg::IDX_W'(1);
          if (clr_cnt_q == ptsm_pkg::IDX_W'(ptsm_pkg::ENTRIES_PER_TABLE - 1)) begin
            state_q <= clr_to_done_q ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (upper) begin
            if (!present) begin
              if (pool_full) begin
                status_q <= ptsm_pkg::STAT_POOL_FAULT;
                state_q  <= S_DONE;
              end else begin
                // link written this cycle, then sweep the new child table
                tbl_q         <= next_tbl_q[ptsm_pkg::TBL_W-1:0];
                next_tbl_q    <= next_tbl_q + ptsm_pkg::CNT_W'(1);
                lvl_q         <= lvl_q + ptsm_pkg::LVL_W'(1);
                clr_cnt_q     <= '0;
                clr_to_done_q <= 1'b0;
                state_q       <= S_CLEAR;
              end
            end else if (!child_ok) begin
              status_q <= ptsm_pkg::STAT_POOL_FAULT;
              state_q  <= S_DONE;
            end else begin
              tbl_q   <= child_off[ptsm_pkg::TBL_W-1:0];
              lvl_q   <= lvl_q + ptsm_pkg::LVL_W'(1);
              state_q <= S_READ;
            end
          end else begin
            if (present) begin
              status_q <= ptsm_pkg::STAT_LEAF_PRESENT;
              leaf_q   <= ram_rdata;
            end else begin
              leaf_q <= leaf_new;
              if (!is_data_q) begin
                next_user_q <= next_user_q + 32'd1;
              end
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status     <= status_q;
            out_q.root_frame <= root_q;
            out_q.leaf_entry <= leaf_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_tbl_q <= ptsm_pkg::CNT_W'(ptsm_pkg::TABLE_FRAMES))
    else $error("table pool counter beyond pool size");

  a_pool_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (next_tbl_q == $past(next_tbl_q)) ||
             (next_tbl_q == $past(next_tbl_q) + ptsm_pkg::CNT_W'(1)))
    else $error("table pool counter jumped");

  a_user_only_at_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EVAL) |=> $stable(next_user_q))
    else $error("user frame taken outside leaf update");

  a_eval_write_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && ram_we) |-> ram_wdata[0])
    else $error("walk wrote an entry without present bit");

  a_map_clear_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !clr_to_done_q) |-> (lvl_q != '0))
    else $error("child table sweep without level advance");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while output register busy");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the page table segment mapper core
module tb;
  import ptsm_pkg::*;

  // kind code with no name in the package, handled as stack
  localparam logic [1:0] KIND_SPARE = 2'd3;

  class page_map_tracker;
    bit [PTE_W-1:0]   store [STORE_DEPTH];
    int unsigned      tables_used;
    bit [FRAME_W-1:0] user_count;
    bit [FRAME_W-1:0] root;
    bit               ctx_open;
    bit [FRAME_W-1:0] data_frame;
    bit [FRAME_W-1:0] table_base;
    bit [FRAME_W-1:0] user_base;
    out_item_t        pending_replies [$];
    int               errors;

    function void set_reg(reg_idx_e idx, bit [FRAME_W-1:0] val);
      case (idx)
        REG_DATA_FRAME: data_frame = val;
        REG_TABLE_BASE: table_base = val;
        REG_USER_BASE:  user_base  = val;
        default: ;
      endcase
    endfunction

    // take the next pool table and sweep it to zero
    function bit grab_table(output int unsigned t);
      if (tables_used >= TABLE_FRAMES) return 1'b0;
      t = tables_used;
      tables_used++;
      for (int k = 0; k < ENTRIES_PER_TABLE; k++) store[t*ENTRIES_PER_TABLE + k] = '0;
      return 1'b1;
    endfunction

    function bit local_table(bit [FRAME_W-1:0] frame, output int unsigned t);
      bit [FRAME_W-1:0] off;
      off = frame - table_base;
      t   = off;
      return off < tables_used;
    endfunction

    // one upper level of the walk, creating the next table when missing
    function bit step_down(int unsigned tbl, bit [IDX_W-1:0] idx, bit wr,
                           output int unsigned child);
      int unsigned      a;
      int unsigned      t;
      bit [FRAME_W-1:0] f;
      a = tbl*ENTRIES_PER_TABLE + idx;
      if (!store[a][0]) begin
        if (!grab_table(t)) return 1'b0;
        f = table_base + t;
        store[a] |= (64'(f) << PAGE_SHIFT) | PTE_PU;
        child = t;
      end else if (!local_table(store[a][43:12], child)) begin
        return 1'b0;
      end
      if (wr) store[a] |= PTE_WRITE;
      return 1'b1;
    endfunction

    function void note_request(in_item_t it);
      out_item_t        r;
      bit [VA_W-1:0]    va;
      int unsigned      tbl;
      int unsigned      t;
      int unsigned      a;
      bit               ok;
      bit [FRAME_W-1:0] frame;
      r.status     = STAT_DONE;
      r.leaf_entry = '0;
      if (it.command == CMD_NEW_CONTEXT) begin
        if (grab_table(t)) begin
          root     = table_base + t;
          ctx_open = 1'b1;
        end else begin
          r.status = STAT_POOL_FAULT;
        end
      end else if (!ctx_open) begin
        r.status = STAT_NO_CONTEXT;
      end else begin
        if (it.segment_kind == KIND_CODE || it.segment_kind == KIND_DATA) begin
          va = it.segment_start;
        end else begin
          va = it.segment_end - PAGE_SIZE;
        end
        ok = local_table(root, tbl);
        if (ok) ok = step_down(tbl, va[47:39], it.writable, tbl);
        if (ok) ok = step_down(tbl, va[38:30], it.writable, tbl);
        if (ok) ok = step_down(tbl, va[29:21], it.writable, tbl);
        if (!ok) begin
          r.status = STAT_POOL_FAULT;
        end else begin
          a = tbl*ENTRIES_PER_TABLE + va[20:12];
          if (store[a][0]) begin
            r.status = STAT_LEAF_PRESENT;
          end else begin
            if (it.segment_kind == KIND_DATA) begin
              frame = data_frame;
            end else begin
              frame = user_base + user_count;
              user_count++;
            end
            store[a] |= (64'(frame) << PAGE_SHIFT) | PTE_PU;
            if (it.writable) store[a] |= PTE_WRITE;
          end
          r.leaf_entry = store[a];
        end
      end
      r.root_frame = root;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected item status=%0d root=%h leaf=%h", $time,
                 got.status, got.root_frame, got.leaf_entry);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.root_frame !== want.root_frame) begin
        errors++;
        $display("%0t: root_frame expected %h, got %h", $time,
                 want.root_frame, got.root_frame);
      end
      if (got.leaf_entry !== want.leaf_entry) begin
        errors++;
        $display("%0t: leaf_entry expected %h, got %h", $time,
                 want.leaf_entry, got.leaf_entry);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  page_map_tracker tracker = new;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  bit [26:0]       region_tag [4];

  page_table_segment_mapper_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_reply(out_item_o);
  end

  task automatic program_reg(reg_idx_e idx, bit [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic load_regs(bit [31:0] dframe, bit [31:0] tbase, bit [31:0] ubase);
    program_reg(REG_DATA_FRAME, dframe);
    program_reg(REG_TABLE_BASE, tbase);
    program_reg(REG_USER_BASE, ubase);
  endtask

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_request(it);
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t map_req(logic [1:0] kind, logic [VA_W-1:0] va_start,
                                       logic [VA_W-1:0] va_end, logic wr);
    in_item_t it;
    it.command       = CMD_MAP;
    it.segment_kind  = kind;
    it.segment_start = va_start;
    it.segment_end   = va_end;
    it.writable      = wr;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t         it;
    bit [VA_W-1:0]    va;
    bit [IDX_W-1:0]   leaf;
    int unsigned      pick;
    pick             = $urandom_range(99);
    it.command       = (pick >= 2) ? CMD_MAP : CMD_NEW_CONTEXT;
    it.segment_kind  = 2'($urandom_range(3));
    it.writable      = 1'($urandom_range(1));
    it.segment_start = 48'({$urandom, $urandom});
    it.segment_end   = 48'({$urandom, $urandom});
    // most maps land in a few known regions so the leaf tables fill up
    if (pick >= 6) begin
      leaf = $urandom_range(1) ? 9'($urandom_range(15)) : 9'($urandom);
      va   = {region_tag[$urandom_range(3)], leaf, 12'($urandom)};
      if (it.segment_kind == KIND_CODE || it.segment_kind == KIND_DATA) begin
        it.segment_start = va;
      end else begin
        it.segment_end = va + PAGE_SIZE;
      end
    end
    return it;
  endfunction

  task automatic run_directed();
    in_item_t warmup [$];
    in_item_t ctx;
    ctx         = map_req(KIND_CODE, '1, '1, 1'b1);
    ctx.command = CMD_NEW_CONTEXT;
    warmup.push_back(map_req(KIND_CODE, 48'h0, 48'h0, 1'b0));
    warmup.push_back(ctx);
    warmup.push_back(map_req(KIND_CODE, 48'h0, 48'h0, 1'b0));
    warmup.push_back(map_req(KIND_CODE, 48'hFFFF_FFFF_F000, 48'h0, 1'b1));
    // stack below address zero wraps to the top page, already mapped
    warmup.push_back(map_req(KIND_STACK, 48'h0, 48'h0, 1'b0));
    warmup.push_back(map_req(KIND_DATA, 48'h1000, 48'h0, 1'b1));
    // user frame (user base plus counter) wraps around to zero here
    warmup.push_back(map_req(KIND_SPARE, 48'h0, 48'h3000, 1'b0));
    warmup.push_back(map_req(KIND_STACK, 48'hFFFF_FFFF_FFFF, 48'h1000, 1'b1));
    warmup.push_back(map_req(KIND_CODE, 48'h0000_8000_0000, 48'h0, 1'b0));
    warmup.push_back(map_req(KIND_DATA, 48'h0080_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0));
    warmup.push_back(map_req(KIND_CODE, 48'h7FFF_FFFF_F000, 48'h0, 1'b1));
    warmup.push_back(map_req(KIND_CODE, 48'h0000_0000_1FFF, 48'h0, 1'b0));
    warmup.push_back(ctx);
    warmup.push_back(map_req(KIND_CODE, 48'h0, 48'h0, 1'b1));
    warmup.push_back(map_req(KIND_STACK, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b1));
    warmup.push_back(map_req(KIND_DATA, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0));
    foreach (warmup[n]) send_item(warmup[n]);
    drain();
  endtask

  task automatic run_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct,
                           bit [31:0] dframe, bit [31:0] tbase, bit [31:0] ubase,
                           bit hold_mid);
    in_item_t it;
    load_regs(dframe, tbase, ubase);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      it = random_item();
      // first a map against the old root, then a fresh context
      if (n == 0) it.command = CMD_MAP;
      if (n == 1) it.command = CMD_NEW_CONTEXT;
      if (hold_mid && n == count/2) drain();
      send_item(it);
    end
    drain();
  endtask

  initial begin
    bit [8:0] top_a;
    bit [8:0] top_b;
    top_a = 9'($urandom);
    top_b = 9'($urandom);
    foreach (region_tag[r]) region_tag[r] = {(r < 2) ? top_a : top_b, 18'($urandom)};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    run_directed();
    run_phase(60, 62, 0, 32'h0, 32'h0, 32'h0, 1'b0);
    run_phase(100, 0, 62, $urandom, 32'h1000_0000, $urandom, 1'b1);
    run_phase(100, 18, 18, $urandom, 32'h1000_0000, $urandom, 1'b0);
    run_phase(94, 0, 0, $urandom, 32'h1000_0000, 32'hFFFF_FFF0, 1'b0);
    repeat (1600) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
